// ===== sv/channel_fragment_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// Channel fragment decoder assertion macros
// Shared assertion forms for the decoder checker.
// ---------------------------------------------------------------------------
`ifndef CHANNEL_FRAGMENT_DECODER_MACROS_SVH
`define CHANNEL_FRAGMENT_DECODER_MACROS_SVH

// same-cycle implication, off while reset is high
`define CFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Channel fragment decoder package
// Types, constants and character classification shared by the decoder.
// ---------------------------------------------------------------------------
package cfd_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int HEADER_BYTES = 6;
   localparam int CNT_W        = COUNT_WIDTH + 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 80;

   localparam logic [7:0] PREFIX_TEXT [4] = '{8'h52, 8'h4E, 8'h53, 8'h3A};
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [5:0] SEXTET_DASH  = 6'd62;
   localparam logic [5:0] SEXTET_UNDER = 6'd63;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_PREFIX    = 3'd1,
      ST_CHAR      = 3'd2,
      ST_SHORT     = 3'd3,
      ST_NUMBERING = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      TK_SKIP,
      TK_SPACE,
      TK_PAD,
      TK_SEXTET,
      TK_BAD
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] sextet;
      logic       fin;
      logic       pfx_err;
   } token_type;

   typedef struct packed {
      logic [15:0] payload_count;
      logic [7:0]  frag_tot;
      logic [31:0] packet_id;
      logic [7:0]  frag_index;
      status_type  status;
      logic [7:0]  payload_byte;
   } rsp_body_type;

   typedef struct packed {
      logic         byte_valid;
      logic         done_res;
      rsp_body_type body;
   } result_type;

   function automatic token_type classify(input logic [7:0] c);
      token_type t;
      t = '{kind: TK_BAD, sextet: 6'd0, fin: 1'b0, pfx_err: 1'b0};
      if (c == CHAR_SPACE || c == CHAR_CR || c == CHAR_LF) begin
         t.kind = TK_SPACE;
      end else if (c == CHAR_PAD) begin
         t.kind = TK_PAD;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         t.kind   = TK_SEXTET;
         t.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t.kind   = TK_SEXTET;
         t.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t.kind   = TK_SEXTET;
         t.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == CHAR_DASH) begin
         t.kind   = TK_SEXTET;
         t.sextet = SEXTET_DASH;
      end else if (c == CHAR_UNDER) begin
         t.kind   = TK_SEXTET;
         t.sextet = SEXTET_UNDER;
      end
      return t;
   endfunction

endpackage

// ===== sv/channel_fragment_decoder.sv =====
// ---------------------------------------------------------------------------
// Channel fragment decoder
// Checks the "RNS:" prefix, base64url-decodes the rest of a text message,
// splits off a six-byte header and streams the payload bytes.
//
//   channel | direction | tdata                  | tuser      | tlast
//   req_    | in        | char_code              | -          | final_char
//   rsp_    | out       | byte, status, header,  | byte_valid | done_res
//           |           | payload count          |            |
//
// One character per cycle while the output is not stalled; the front classifies in the accept
// cycle and the back decodes one token per cycle from a two-entry queue.
// An accepted character is held in a queue slot and then in the result register.
// Reset clears all control state; no clearing pass is needed.
// A stalled output holds its register and the queue absorbs up to two items.
// ---------------------------------------------------------------------------
module channel_fragment_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [7:0] char_code
   input  logic [cfd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] payload_byte, [10:8] status, [18:11] frag_index,
   // [50:19] packet_id, [58:51] fragment total, [74:59] payload_count, [79:75] zero
   output logic [cfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] byte_valid
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);
   import cfd_pkg::*;

   logic       q_full, q_push, q_pop, q_not_empty;
   token_type  push_tok, pop_tok;
   result_type res;

   cfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .char_code  (req_tdata[7:0]),
      .final_char (req_tlast),
      .queue_full (q_full),
      .push       (q_push),
      .push_tok   (push_tok)
   );

   cfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_tok  (push_tok),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_tok   (pop_tok)
   );

   cfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (q_not_empty),
      .tok        (pop_tok),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (res)
   );

   assign rsp_tdata = RSP_DATA_W'(res.body);
   assign rsp_tuser = res.byte_valid;
   assign rsp_tlast = res.done_res;

endmodule

// ===== sv/cfd_queue.sv =====
// ---------------------------------------------------------------------------
// Token queue
// Short register queue between the classifying front and the decoding back.
// ---------------------------------------------------------------------------
module cfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cfd_pkg::token_type push_tok,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output cfd_pkg::token_type pop_tok
);
   import cfd_pkg::*;

   token_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_tok   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

// ===== sv/cfd_front.sv =====
// ---------------------------------------------------------------------------
// Decoder front
// Accepts characters, checks the prefix and classifies the rest into tokens.
// ---------------------------------------------------------------------------
module cfd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         char_code,
   input  logic               final_char,
   input  logic               queue_full,
   output logic               push,
   output cfd_pkg::token_type push_tok
);
   import cfd_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       prefix_bad_ff, prefix_bad_in;
   logic       accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;
   assign push       = accept;

   always_comb begin
      pos_in        = pos_ff;
      prefix_bad_in = prefix_bad_ff;
      push_tok      = '{kind: TK_SKIP, sextet: 6'd0, fin: 1'b0, pfx_err: 1'b0};
      if (pos_ff < 3'd4) begin
         if (char_code != PREFIX_TEXT[pos_ff[1:0]]) begin
            prefix_bad_in = 1'b1;
         end
         pos_in = pos_ff + 3'd1;
      end else if (!prefix_bad_ff) begin
         push_tok = classify(char_code);
      end
      push_tok.fin     = final_char;
      push_tok.pfx_err = prefix_bad_in || (pos_in < 3'd4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         prefix_bad_ff <= 1'b0;
      end else if (accept) begin
         if (final_char) begin
            pos_ff        <= '0;
            prefix_bad_ff <= 1'b0;
         end else begin
            pos_ff        <= pos_in;
            prefix_bad_ff <= prefix_bad_in;
         end
      end
   end

endmodule

// ===== sv/cfd_back.sv =====
// ---------------------------------------------------------------------------
// Decoder back
// Runs the base64url bit buffer, collects the header and registers results.
// ---------------------------------------------------------------------------
module cfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   input  cfd_pkg::token_type  tok,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output cfd_pkg::result_type rsp_res
);
   import cfd_pkg::*;

   localparam logic [CNT_W-1:0] HDR_CNT    = CNT_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] BYTE_LIMIT =
      CNT_W'((64'd1 << COUNT_WIDTH) - 64'd1 + 64'(HEADER_BYTES));

   logic             pad_ff, pad_in;
   logic             space_ff, space_in;
   logic             bad_ff, bad_in;
   logic [11:0]      buf_ff, buf_in;
   logic [2:0]       bits_ff, bits_in;
   logic [CNT_W-1:0] bytes_ff, bytes_in;
   logic [47:0]      hdr_ff, hdr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff, rsp_res_in;

   logic [3:0]       bits_add;
   logic [2:0]       bits_sub;
   logic [7:0]       dec_byte;
   logic             have;
   logic [CNT_W-1:0] pc_wide;
   logic [32:0]      pc_ext;
   status_type       st;

   assign pop        = tok_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_res    = rsp_res_ff;

   always_comb begin
      pad_in   = pad_ff;
      space_in = space_ff;
      bad_in   = bad_ff;
      buf_in   = buf_ff;
      bits_in  = bits_ff;
      bytes_in = bytes_ff;
      hdr_in   = hdr_ff;
      have     = 1'b0;
      bits_add = 4'(bits_ff) + 4'd6;
      bits_sub = 3'(bits_add - 4'd8);
      dec_byte = '0;
      if (tok.kind != TK_SKIP && !bad_ff && !pad_ff) begin
         if (tok.kind == TK_SPACE) begin
            space_in = 1'b1;
         end else if (space_ff) begin
            bad_in = 1'b1;
         end else if (tok.kind == TK_PAD) begin
            pad_in = 1'b1;
         end else if (tok.kind == TK_BAD) begin
            bad_in = 1'b1;
         end else begin
            buf_in = {buf_ff[5:0], tok.sextet};
            if (bits_add >= 4'd8) begin
               bits_in  = bits_sub;
               dec_byte = 8'(buf_in >> bits_sub);
               if (bytes_ff < HDR_CNT) begin
                  hdr_in = {hdr_ff[39:0], dec_byte};
               end else begin
                  have = 1'b1;
               end
               if (bytes_ff < BYTE_LIMIT) begin
                  bytes_in = bytes_ff + 1'b1;
               end
            end else begin
               bits_in = 3'(bits_add);
            end
         end
      end

      pc_wide = (bytes_in >= HDR_CNT) ? bytes_in - HDR_CNT : '0;
      pc_ext  = 33'(pc_wide);

      if (tok.pfx_err) begin
         st = ST_PREFIX;
      end else if (bad_in) begin
         st = ST_CHAR;
      end else if (bytes_in < HDR_CNT) begin
         st = ST_SHORT;
      end else if (hdr_in[7:0] == 8'd0 || hdr_in[47:40] >= hdr_in[7:0]) begin
         st = ST_NUMBERING;
      end else begin
         st = ST_OK;
      end

      rsp_res_in                   = '0;
      rsp_res_in.byte_valid        = have;
      rsp_res_in.body.payload_byte = have ? dec_byte : 8'd0;
      rsp_res_in.body.status       = ST_OK;
      if (tok.fin) begin
         rsp_res_in.done_res           = 1'b1;
         rsp_res_in.body.status        = st;
         rsp_res_in.body.payload_count = (pc_ext > 33'h0_FFFF) ? 16'hFFFF : pc_ext[15:0];
         if (st == ST_OK || st == ST_NUMBERING) begin
            rsp_res_in.body.frag_index = hdr_in[47:40];
            rsp_res_in.body.packet_id  = hdr_in[39:8];
            rsp_res_in.body.frag_tot   = hdr_in[7:0];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = have || tok.fin;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff       <= 1'b0;
         space_ff     <= 1'b0;
         bad_ff       <= 1'b0;
         buf_ff       <= '0;
         bits_ff      <= '0;
         bytes_ff     <= '0;
         hdr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (tok.fin) begin
               pad_ff   <= 1'b0;
               space_ff <= 1'b0;
               bad_ff   <= 1'b0;
               buf_ff   <= '0;
               bits_ff  <= '0;
               bytes_ff <= '0;
               hdr_ff   <= '0;
            end else begin
               pad_ff   <= pad_in;
               space_ff <= space_in;
               bad_ff   <= bad_in;
               buf_ff   <= buf_in;
               bits_ff  <= bits_in;
               bytes_ff <= bytes_in;
               hdr_ff   <= hdr_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_res_ff <= rsp_res_in;
      end
   end

endmodule

// ===== sv/cfd_checker.sv =====
// ---------------------------------------------------------------------------
// Channel fragment decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "channel_fragment_decoder_macros.svh"

module cfd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [cfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                          rsp_tuser,
   input logic                          rsp_tlast
);
   import cfd_pkg::*;

   `CFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp item changed while stalled")
   `CFD_ASSERT_NOW(a_mid_fields_zero, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser && rsp_tdata[79:8] == '0, "non-final item carries status fields or no byte")
   `CFD_ASSERT_NOW(a_no_byte_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[7:0] == 8'd0, "payload byte set without byte_valid")
   `CFD_ASSERT_NOW(a_hdr_by_status, clock, reset, rsp_tvalid && rsp_tlast && rsp_tdata[10:8] != ST_OK && rsp_tdata[10:8] != ST_NUMBERING, rsp_tdata[58:11] == '0, "header shown with error status")

endmodule

bind channel_fragment_decoder cfd_checker u_cfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
